### src/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants for the secure memory card slot block.
// ----------------------------------------------------------------------------
package smc_pkg;

	localparam int SLOT_COUNT_DEF      = 4;
	localparam int DATA_BYTES_DEF      = 256;
	localparam int PROTECTED_BYTES_DEF = 32;

	localparam logic [7:0] BYTE_ONES    = 8'hFF;
	localparam logic [7:0] COUNTER_FULL = 8'h07;

	typedef enum logic [3:0] {
		OP_RDATA   = 4'd0,
		OP_WDATA   = 4'd1,
		OP_RPROT   = 4'd2,
		OP_WPROT   = 4'd3,
		OP_RSEC    = 4'd4,
		OP_WSEC    = 4'd5,
		OP_AUTH    = 4'd6,
		OP_LOADRAW = 4'd7,
		OP_DUMPRAW = 4'd8,
		OP_SETINS  = 4'd9,
		OP_EJECT   = 4'd10
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [1:0] slot;
		logic [8:0] address;
		logic [7:0] write_value;
		logic [7:0] pin_first;
		logic [7:0] pin_second;
		logic [7:0] pin_third;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       is_authenticated;
		logic       is_dirty;
		logic       is_present;
	} rsp_t;

endpackage

### src/smc_data_mem.sv
// ----------------------------------------------------------------------------
// smc_data_mem
// Card data byte store: one write and one registered read port, filled with
// all-ones by a sweep after reset.
// ----------------------------------------------------------------------------
module smc_data_mem #(
	parameter int DEPTH = smc_pkg::SLOT_COUNT_DEF * smc_pkg::DATA_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	output logic                     busy
);
	import smc_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			mem[clr_addr_q] <= BYTE_ONES;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_active_q;

endmodule

### src/smc_card_ctrl.sv
// ----------------------------------------------------------------------------
// smc_card_ctrl
// Per-slot card state (flags, protection and security bytes) and the
// operation decode that turns one beat into its result and store updates.
// ----------------------------------------------------------------------------
module smc_card_ctrl #(
	parameter int SLOT_COUNT      = smc_pkg::SLOT_COUNT_DEF,
	parameter int DATA_BYTES      = smc_pkg::DATA_BYTES_DEF,
	parameter int PROTECTED_BYTES = smc_pkg::PROTECTED_BYTES_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     fire,
	input  smc_pkg::req_t                            item,
	input  logic [7:0]                               mem_data,
	output logic                                     wr_en,
	output logic [$clog2(SLOT_COUNT*DATA_BYTES)-1:0] wr_addr,
	output logic [7:0]                               wr_data,
	output smc_pkg::rsp_t                            result
);
	import smc_pkg::*;

	localparam int MEM_AW     = $clog2(SLOT_COUNT * DATA_BYTES);
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CARD_BYTES = DATA_BYTES + 8;

	logic [SLOT_COUNT-1:0] loaded_q;
	logic [SLOT_COUNT-1:0] inserted_q;
	logic [SLOT_COUNT-1:0] auth_q;
	logic [SLOT_COUNT-1:0] dirty_q;
	logic [3:0][7:0]       prot_q [SLOT_COUNT];
	logic [3:0][7:0]       sec_q  [SLOT_COUNT];

	logic              slot_ok;
	logic [SLOT_W-1:0] sidx;
	logic              data_ok;
	logic              small_ok;
	logic              raw_ok;
	logic              prot_area;
	logic [31:0]       raw_off;
	logic [1:0]        raw_idx;
	logic              raw_sec;
	logic [1:0]        bidx;
	logic [3:0][7:0]   prot_row;
	logic [3:0][7:0]   sec_row;
	logic [7:0]        pbyte;
	logic              pbit;
	logic              loaded;
	logic              authed;
	logic              pin_match;
	logic [7:0]        v;

	logic            ld_n;
	logic            ins_n;
	logic            au_n;
	logic            dt_n;
	logic [3:0][7:0] prot_n;
	logic [3:0][7:0] sec_n;
	logic [7:0]      rd;
	logic            we;

	always_comb begin
		slot_ok   = 32'(item.slot) < SLOT_COUNT;
		sidx      = slot_ok ? SLOT_W'(item.slot) : '0;
		v         = item.write_value;
		data_ok   = 32'(item.address) < DATA_BYTES;
		small_ok  = item.address < 9'd4;
		raw_ok    = 32'(item.address) < CARD_BYTES;
		prot_area = 32'(item.address) < PROTECTED_BYTES;
		raw_off   = 32'(item.address) - DATA_BYTES;
		raw_idx   = raw_off[1:0];
		raw_sec   = raw_off[2];
		bidx      = item.address[1:0];
		prot_row  = prot_q[sidx];
		sec_row   = sec_q[sidx];
		pbyte     = prot_row[item.address[4:3]];
		pbit      = pbyte[item.address[2:0]];
		loaded    = loaded_q[sidx];
		authed    = auth_q[sidx];
		pin_match = (sec_row[1] == item.pin_first) && (sec_row[2] == item.pin_second) &&
			(sec_row[3] == item.pin_third);

		ld_n   = loaded_q[sidx];
		ins_n  = inserted_q[sidx];
		au_n   = auth_q[sidx];
		dt_n   = dirty_q[sidx];
		prot_n = prot_row;
		sec_n  = sec_row;
		rd     = BYTE_ONES;
		we     = 1'b0;

		case (item.operation)
			OP_RDATA: begin
				if (loaded && data_ok) rd = mem_data;
			end
			OP_WDATA: begin
				if (loaded && data_ok && authed && (!prot_area || pbit)) begin
					we   = 1'b1;
					dt_n = 1'b1;
				end
			end
			OP_RPROT: begin
				if (loaded && small_ok) rd = prot_row[bidx];
			end
			OP_WPROT: begin
				if (loaded && small_ok && authed) begin
					prot_n[bidx] = prot_row[bidx] & v;
					dt_n         = 1'b1;
				end
			end
			OP_RSEC: begin
				if (loaded && small_ok && authed) rd = sec_row[bidx];
			end
			OP_WSEC: begin
				if (loaded && small_ok && authed) begin
					sec_n[bidx] = v;
					dt_n        = 1'b1;
				end
			end
			OP_AUTH: begin
				if (!loaded) begin
					au_n = 1'b0;
				end else if (pin_match) begin
					if (sec_row[0][2:0] != 3'd0) begin
						au_n     = 1'b1;
						sec_n[0] = COUNTER_FULL;
					end
				end else begin
					au_n     = 1'b0;
					sec_n[0] = sec_row[0] >> 1;
				end
			end
			OP_LOADRAW: begin
				if (raw_ok) begin
					if (data_ok) begin
						we = 1'b1;
					end else if (raw_sec) begin
						sec_n[raw_idx] = v;
					end else begin
						prot_n[raw_idx] = v;
					end
					ld_n  = 1'b1;
					ins_n = 1'b1;
					au_n  = 1'b0;
					dt_n  = 1'b0;
				end
			end
			OP_DUMPRAW: begin
				if (loaded && raw_ok) begin
					if (data_ok) begin
						rd = mem_data;
					end else if (raw_sec) begin
						rd = sec_row[raw_idx];
					end else begin
						rd = prot_row[raw_idx];
					end
					dt_n = 1'b0;
				end
			end
			OP_SETINS: begin
				if (v[0]) begin
					ins_n = 1'b1;
				end else begin
					ins_n = 1'b0;
					au_n  = 1'b0;
				end
			end
			OP_EJECT: begin
				ins_n = 1'b0;
				au_n  = 1'b0;
				dt_n  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign wr_en   = fire && slot_ok && we;
	assign wr_addr = MEM_AW'(32'(sidx) * DATA_BYTES + 32'(item.address));
	assign wr_data = v;

	assign result.read_byte        = slot_ok ? rd : BYTE_ONES;
	assign result.is_authenticated = slot_ok && au_n;
	assign result.is_dirty         = slot_ok && dt_n;
	assign result.is_present       = slot_ok && ld_n && ins_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q   <= '0;
			inserted_q <= '0;
			auth_q     <= '0;
			dirty_q    <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				prot_q[i] <= {BYTE_ONES, BYTE_ONES, BYTE_ONES, BYTE_ONES};
				sec_q[i]  <= {BYTE_ONES, BYTE_ONES, BYTE_ONES, COUNTER_FULL};
			end
		end else if (fire && slot_ok) begin
			loaded_q[sidx]   <= ld_n;
			inserted_q[sidx] <= ins_n;
			auth_q[sidx]     <= au_n;
			dirty_q[sidx]    <= dt_n;
			prot_q[sidx]     <= prot_n;
			sec_q[sidx]      <= sec_n;
		end
	end

endmodule

### src/secure_memory_card_slots.sv
// ----------------------------------------------------------------------------
// secure_memory_card_slots
// Pipeline: the request beat is registered together with the data store read,
// then decoded with the state update into the response register.
// Throughput: one request per cycle while a held response does not stall, set by
// the registered read of the data store with write-to-read forwarding.
// Reset: flags cleared at once; req_ready stays low while all SLOT_COUNT*DATA_BYTES
// bytes (1024 by default) of the data store are swept to all-ones.
// ----------------------------------------------------------------------------
module secure_memory_card_slots #(
	parameter int SLOT_COUNT      = smc_pkg::SLOT_COUNT_DEF,
	parameter int DATA_BYTES      = smc_pkg::DATA_BYTES_DEF,
	parameter int PROTECTED_BYTES = smc_pkg::PROTECTED_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  smc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output smc_pkg::rsp_t rsp
);
	import smc_pkg::*;

	localparam int MEM_DEPTH = SLOT_COUNT * DATA_BYTES;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic              s1_valid_q;
	req_t              req_s1;
	logic              fwd_s1;
	logic [7:0]        fwd_data_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              s1_adv;
	logic              fire;
	logic              req_acc;
	logic              mem_busy;
	logic              slot_ok_in;
	logic [SLOT_W-1:0] sidx_in;
	logic              rd_en;
	logic [MEM_AW-1:0] rd_addr;
	logic [7:0]        mem_rdata;
	logic [7:0]        mem_data;
	logic              wr_en;
	logic [MEM_AW-1:0] wr_addr;
	logic [7:0]        wr_data;
	rsp_t              result;

	assign s1_adv    = !rsp_valid_q || rsp_ready;
	assign fire      = s1_valid_q && s1_adv;
	assign req_ready = !mem_busy && (!s1_valid_q || s1_adv);
	assign req_acc   = req_valid && req_ready;

	assign slot_ok_in = 32'(req.slot) < SLOT_COUNT;
	assign sidx_in    = slot_ok_in ? SLOT_W'(req.slot) : '0;
	assign rd_addr    = MEM_AW'(32'(sidx_in) * DATA_BYTES + 32'(req.address));
	assign rd_en      = req_acc && slot_ok_in && (32'(req.address) < DATA_BYTES);
	assign mem_data   = fwd_s1 ? fwd_data_s1 : mem_rdata;

	smc_data_mem #(
		.DEPTH(MEM_DEPTH)
	) u_data_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(mem_rdata),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.busy   (mem_busy)
	);

	smc_card_ctrl #(
		.SLOT_COUNT     (SLOT_COUNT),
		.DATA_BYTES     (DATA_BYTES),
		.PROTECTED_BYTES(PROTECTED_BYTES)
	) u_card_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (req_s1),
		.mem_data(mem_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= s1_valid_q;
			end
		end
	end

	// same-cycle write from the stage ahead wins over the stored byte
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1      <= req;
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### src/smc_checker.sv
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks for the secure memory card slot block, bound to the top.
// ----------------------------------------------------------------------------
module smc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input smc_pkg::rsp_t rsp
);
	import smc_pkg::*;

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat dropped or changed while stalled");

	// a new response needs an earlier request taken into the request stage
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response beat without a matching request");

	// store fill keeps requests out right after reset
	a_fill_block: assert property (@(posedge clk)
		$rose(arst_n) |-> !req_ready)
		else $error("request taken during store fill");

	// full pipeline with stalled output takes no more requests
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready && $past(req_valid && req_ready) |-> !req_ready)
		else $error("request taken while pipeline full");

endmodule

bind secure_memory_card_slots smc_checker u_smc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
